// ----- rtl/rsqe_pkg.sv -----
package rsqe_pkg;

	// Step counts of the shared sqrt/divide unit.
	localparam int SQRT_STEPS = 32;
	localparam int DIV_QBITS  = 25;
	localparam int NUM_W      = 58;
	localparam int CNT_W      = 6;

	localparam logic OP_SQRT = 1'b0;
	localparam logic OP_DIV  = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
	} unit_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] result;
	} unit_rsp_t;

endpackage

// ----- rtl/road_segment_quad_expander.sv -----
// Channel  | Direction | Contents
// s_axis   | in        | one polyline point per request; tuser flags first point and type
// m_axis   | out       | six vertices per segment, tlast on the sixth
//
// A first point of an edge is stored and yields no vertices.
// A segment point runs a shift-by-one normalize loop, a 32-step square
// root and two 25-step divides on the shared unit, four products on one
// multiplier, then six vertex loads.
// A zero-length segment skips the arithmetic and goes straight to the vertex loads.
// Reset clears the sequencer, the stored-point flag and the output valid.
// The output register lets a new point be accepted while the last vertex
// waits; a stalled output holds the sequencer in the vertex phase.
module road_segment_quad_expander (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_x, point_y, width_base, height, color
	input  logic [151:0] s_axis_tdata,
	// first_point, road_type
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vert_x, vert_y, vert_z, vert_color
	output logic [127:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ABS  = 4'd1;
	localparam logic [3:0] S_NORM = 4'd2;
	localparam logic [3:0] S_MAA  = 4'd3;
	localparam logic [3:0] S_MBB  = 4'd4;
	localparam logic [3:0] S_SUM  = 4'd5;
	localparam logic [3:0] S_SQST = 4'd6;
	localparam logic [3:0] S_SQRT = 4'd7;
	localparam logic [3:0] S_MBH  = 4'd8;
	localparam logic [3:0] S_MAH  = 4'd9;
	localparam logic [3:0] S_NY   = 4'd10;
	localparam logic [3:0] S_DIVX = 4'd11;
	localparam logic [3:0] S_DIVY = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	localparam logic [1:0] RT_AVENUE  = 2'd2;
	localparam logic [1:0] RT_HIGHWAY = 2'd3;

	logic [3:0]         state_q;
	logic               have_prev_q;
	logic [31:0]        prev_x_q, prev_y_q;
	logic signed [31:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [32:0] dx_q, dy_q;
	logic [31:0]        a_q, b_q;
	logic [25:0]        hq_q;
	logic [31:0]        z_q, col_q;
	logic [61:0]        prod_q;
	logic [62:0]        s_q;
	logic [31:0]        len_q;
	logic [rsqe_pkg::NUM_W-1:0] numx_q, numy_q;
	logic [rsqe_pkg::DIV_QBITS-1:0] mx_q, my_q;
	logic               dx_neg_q, dy_pos_q;
	logic [2:0]         vk_q;
	logic               m_valid_q;
	logic [127:0]       m_data_q;
	logic               m_last_q;

	logic               accept;
	logic               first_point;
	logic [1:0]         road_type;
	logic [23:0]        width_base;
	logic signed [32:0] dx_in, dy_in;
	logic [25:0]        hq_in;
	logic [31:0]        m_max;
	logic [30:0]        mul_a, mul_b;
	logic               out_load;

	rsqe_pkg::unit_req_t unit_req;
	rsqe_pkg::unit_rsp_t unit_rsp;
	logic [63:0]         unit_operand;

	logic [1:0]         corner;
	logic signed [31:0] base_x, base_y;
	logic signed [33:0] offx, offy, vx, vy;
	logic               plus;

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF) begin
			sat32 = 32'h7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign first_point   = s_axis_tuser[0];
	assign road_type     = s_axis_tuser[2:1];
	assign width_base    = s_axis_tdata[87:64];

	assign dx_in = $signed({s_axis_tdata[31], s_axis_tdata[31:0]}) -
		$signed({prev_x_q[31], prev_x_q});
	assign dy_in = $signed({s_axis_tdata[63], s_axis_tdata[63:32]}) -
		$signed({prev_y_q[31], prev_y_q});

	// Half width in quarter units: x2.0, x1.5 or x1.0 times one half.
	always_comb begin
		case (road_type)
			RT_HIGHWAY: hq_in = {width_base, 2'b00};
			RT_AVENUE:  hq_in = 26'(width_base) + {1'b0, width_base, 1'b0};
			default:    hq_in = {1'b0, width_base, 1'b0};
		endcase
	end

	assign m_max = (a_q >= b_q) ? a_q : b_q;

	// One shared multiplier; its product is always registered.
	always_comb begin
		case (state_q)
			S_MAA:   begin mul_a = a_q[30:0]; mul_b = a_q[30:0]; end
			S_MBB:   begin mul_a = b_q[30:0]; mul_b = b_q[30:0]; end
			S_MBH:   begin mul_a = b_q[30:0]; mul_b = 31'(hq_q); end
			S_MAH:   begin mul_a = a_q[30:0]; mul_b = 31'(hq_q); end
			default: begin mul_a = a_q[30:0]; mul_b = b_q[30:0]; end
		endcase
	end

	always_comb begin
		unit_req.start = (state_q == S_SQST) || (state_q == S_NY) ||
			(state_q == S_DIVX && unit_rsp.done);
		unit_req.op    = (state_q == S_SQST) ? rsqe_pkg::OP_SQRT : rsqe_pkg::OP_DIV;
		if (state_q == S_SQST) begin
			unit_operand = {1'b0, s_q};
		end else if (state_q == S_NY) begin
			unit_operand = 64'(numx_q);
		end else begin
			unit_operand = 64'(numy_q);
		end
	end

	rsqe_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (unit_req),
		.operand (unit_operand),
		.divisor ({len_q, 2'b00}),
		.rsp     (unit_rsp)
	);

	// Corners in emit order p0, p1, p2, p0, p2, p3.
	always_comb begin
		case (vk_q)
			3'd0:    corner = 2'd0;
			3'd1:    corner = 2'd1;
			3'd2:    corner = 2'd2;
			3'd3:    corner = 2'd0;
			3'd4:    corner = 2'd2;
			3'd5:    corner = 2'd3;
			default: corner = 2'd0;
		endcase
		plus   = corner inside {2'd0, 2'd3};
		base_x = (corner inside {2'd0, 2'd1}) ? x1_q : x2_q;
		base_y = (corner inside {2'd0, 2'd1}) ? y1_q : y2_q;
		offx   = dy_pos_q ? -$signed({9'b0, mx_q}) : $signed({9'b0, mx_q});
		offy   = dx_neg_q ? -$signed({9'b0, my_q}) : $signed({9'b0, my_q});
		vx     = 34'(base_x) + (plus ? offx : -offx);
		vy     = 34'(base_y) + (plus ? offy : -offy);
	end

	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_prev_q <= 1'b0;
			vk_q        <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b1;
						if (!first_point && have_prev_q) begin
							state_q <= S_ABS;
						end
					end
				end
				S_ABS: state_q <= S_NORM;
				S_NORM: begin
					if (m_max == '0) begin
						vk_q    <= '0;
						state_q <= S_OUT;
					end else if (m_max[31] || m_max[30]) begin
						state_q <= S_MAA;
					end
				end
				S_MAA:  state_q <= S_MBB;
				S_MBB:  state_q <= S_SUM;
				S_SUM:  state_q <= S_SQST;
				S_SQST: state_q <= S_SQRT;
				S_SQRT: begin
					if (unit_rsp.done) begin
						state_q <= S_MBH;
					end
				end
				S_MBH:  state_q <= S_MAH;
				S_MAH:  state_q <= S_NY;
				S_NY:   state_q <= S_DIVX;
				S_DIVX: begin
					if (unit_rsp.done) begin
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (unit_rsp.done) begin
						vk_q    <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (vk_q == 3'd5) begin
							state_q <= S_IDLE;
						end else begin
							vk_q <= vk_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 62'(mul_a) * 62'(mul_b);
		if (accept) begin
			prev_x_q <= s_axis_tdata[31:0];
			prev_y_q <= s_axis_tdata[63:32];
			x1_q     <= prev_x_q;
			y1_q     <= prev_y_q;
			x2_q     <= s_axis_tdata[31:0];
			y2_q     <= s_axis_tdata[63:32];
			dx_q     <= dx_in;
			dy_q     <= dy_in;
			hq_q     <= hq_in;
			z_q      <= s_axis_tdata[119:88];
			col_q    <= s_axis_tdata[151:120];
		end
		case (state_q)
			S_ABS: begin
				a_q      <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
				b_q      <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
				dx_neg_q <= dx_q[32];
				dy_pos_q <= !dy_q[32] && (dy_q != '0);
			end
			S_NORM: begin
				// Bring the larger magnitude into [2^30, 2^31), or clear the offsets for a zero-length segment.
				if (m_max == '0) begin
					mx_q <= '0;
					my_q <= '0;
				end else if (m_max[31]) begin
					a_q <= {1'b0, a_q[31:1]};
					b_q <= {1'b0, b_q[31:1]};
				end else if (!m_max[30]) begin
					a_q <= {a_q[30:0], 1'b0};
					b_q <= {b_q[30:0], 1'b0};
				end
			end
			S_MBB: s_q <= {1'b0, prod_q};
			S_SUM: s_q <= s_q + 63'(prod_q);
			S_SQRT: begin
				if (unit_rsp.done) begin
					len_q <= unit_rsp.result;
				end
			end
			S_MAH: numx_q <= rsqe_pkg::NUM_W'(prod_q) + rsqe_pkg::NUM_W'({len_q, 1'b0});
			S_NY:  numy_q <= rsqe_pkg::NUM_W'(prod_q) + rsqe_pkg::NUM_W'({len_q, 1'b0});
			S_DIVX: begin
				if (unit_rsp.done) begin
					mx_q <= unit_rsp.result[rsqe_pkg::DIV_QBITS-1:0];
				end
			end
			S_DIVY: begin
				if (unit_rsp.done) begin
					my_q <= unit_rsp.result[rsqe_pkg::DIV_QBITS-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_data_q <= {col_q, z_q, sat32(vy), sat32(vx)};
			m_last_q <= (vk_q == 3'd5);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		unit_req.start |-> !unit_rsp.busy)
		else $error("shared unit started while busy");

	a_unit_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		unit_rsp.done |-> (state_q == S_SQRT || state_q == S_DIVX || state_q == S_DIVY))
		else $error("shared unit finished with no state waiting for it");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAA |-> (!a_q[31] && !b_q[31] && (a_q[30] || b_q[30])))
		else $error("magnitudes not normalized before the products");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MBH |-> len_q[31:30] != 2'b00)
		else $error("segment length below the normalized range");

endmodule

// ----- rtl/rsqe_unit.sv -----
// Shared digit-recurrence unit: restoring square root (one result bit per
// cycle) and restoring division (one quotient bit per cycle) on one
// compare/subtract datapath.
module rsqe_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rsqe_pkg::unit_req_t      req,
	input  logic [63:0]              operand,
	input  logic [33:0]              divisor,
	output rsqe_pkg::unit_rsp_t      rsp
);

	logic [34:0] rem_q;
	logic [31:0] res_q;
	logic [63:0] src_q;
	logic [33:0] den_q;
	logic [rsqe_pkg::CNT_W-1:0] cnt_q;
	logic        op_q;
	logic        busy_q;
	logic        done_q;

	logic [34:0] cand;
	logic [34:0] trial;
	logic [34:0] diff;
	logic        ge;

	always_comb begin
		if (op_q == rsqe_pkg::OP_SQRT) begin
			cand  = {rem_q[32:0], src_q[63:62]};
			trial = {1'b0, res_q, 2'b01};
		end else begin
			cand  = {rem_q[33:0], src_q[63]};
			trial = {1'b0, den_q};
		end
		ge   = (cand >= trial);
		diff = cand - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= rsqe_pkg::OP_SQRT;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q   <= req.op;
			cnt_q  <= (req.op == rsqe_pkg::OP_SQRT) ?
				rsqe_pkg::CNT_W'(rsqe_pkg::SQRT_STEPS) :
				rsqe_pkg::CNT_W'(rsqe_pkg::DIV_QBITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == rsqe_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// For a division only the low quotient bits are produced, so the top of
	// the numerator is preloaded into the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			res_q <= '0;
			den_q <= divisor;
			if (req.op == rsqe_pkg::OP_SQRT) begin
				rem_q <= '0;
				src_q <= operand;
			end else begin
				rem_q <= 35'(operand[rsqe_pkg::NUM_W-1:rsqe_pkg::DIV_QBITS]);
				src_q <= {operand[rsqe_pkg::DIV_QBITS-1:0],
					{(64 - rsqe_pkg::DIV_QBITS){1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff : cand;
			res_q <= {res_q[30:0], ge};
			src_q <= (op_q == rsqe_pkg::OP_SQRT) ? {src_q[61:0], 2'b00} :
				{src_q[62:0], 1'b0};
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule
